[src/tcpmc_pkg.sv]
`default_nettype none
package tcpmc_pkg;

    localparam int MAX_FRAME = 2048;
    localparam int POS_BITS = $clog2(MAX_FRAME + 2);
    localparam int POS_W = (POS_BITS > 11) ? POS_BITS : 11;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME + 1);

    localparam logic [15:0] ETYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  IP_PROTO_TCP = 8'd6;

    localparam logic [7:0] OPT_END = 8'd0;
    localparam logic [7:0] OPT_NOP = 8'd1;
    localparam logic [7:0] OPT_MSS = 8'd2;
    localparam logic [7:0] OPT_MSS_LEN = 8'd4;

    typedef enum logic [2:0] {
        SCAN_KIND,
        SCAN_LEN_OTHER,
        SCAN_LEN_MSS,
        SCAN_SKIP,
        SCAN_MSS_HI,
        SCAN_MSS_LO,
        SCAN_DONE
    } scan_state_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic        clamp_enable;
        logic [15:0] source_mtu;
        logic [15:0] via_mtu;
        logic        via_is_local;
    } in_item_t;

    typedef struct packed {
        logic        clamp_applied;
        logic [10:0] mss_offset;
        logic [15:0] new_mss;
        logic [10:0] checksum_offset;
        logic [15:0] new_checksum;
        logic [15:0] old_mss;
    } out_item_t;

    typedef struct packed {
        logic        eligible;
        logic [15:0] mss_value;
        logic [10:0] mss_pos;
        logic [6:0]  tcp_start;
        logic [15:0] checksum;
        logic [15:0] eff_mtu;
    } frame_sum_t;

endpackage
`default_nettype wire

[src/tcpmc_parser.sv]
`default_nettype none
module tcpmc_parser (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  step,
    input  wire tcpmc_pkg::in_item_t   in_item,
    output tcpmc_pkg::frame_sum_t      summary
);
    import tcpmc_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      etype_reg, etype_next;
    logic             ip_known_reg, ip_known_next;
    logic             vlan_reg, vlan_next;
    logic [6:0]       tcp_start_reg, tcp_start_next;
    logic             is_tcp_reg, is_tcp_next;
    logic [5:0]       opt_len_reg, opt_len_next;
    logic [5:0]       opt_idx_reg, opt_idx_next;
    scan_state_t      scan_reg, scan_next;
    logic [7:0]       skip_reg, skip_next;
    logic             mss_found_reg, mss_found_next;
    logic [10:0]      mss_pos_reg, mss_pos_next;
    logic [15:0]      mss_value_reg, mss_value_next;
    logic [15:0]      csum_reg, csum_next;
    logic [15:0]      eff_mtu_reg, eff_mtu_next;
    logic             enable_reg, enable_next;

    logic [7:0]       b;
    logic [6:0]       ip_begin7;
    logic [POS_W-1:0] ip_begin;
    logic [POS_W-1:0] ts;
    logic             scan_en;
    logic [8:0]       opt_sum;
    logic [8:0]       idx9;
    logic [8:0]       len9;
    logic [POS_W:0]   count;
    logic [POS_W:0]   ts_next_ext;
    logic [3:0]       doff;

    assign b         = in_item.data_byte;
    assign ip_begin7 = vlan_reg ? 7'd18 : 7'd14;
    assign ip_begin  = {{(POS_W-7){1'b0}}, ip_begin7};
    assign ts        = {{(POS_W-7){1'b0}}, tcp_start_reg};
    assign doff      = b[7:4];
    assign idx9      = {3'b000, opt_idx_reg};
    assign len9      = {3'b000, opt_len_reg};
    assign opt_sum   = idx9 + {1'b0, b};
    assign scan_en   = is_tcp_reg && (tcp_start_reg != 7'd0)
                       && (pos_reg >= ts + POS_W'(20)) && (scan_reg != SCAN_DONE);

    // frame header fields, plus clamp enable and effective MTU from the first byte
    always_comb begin
        pos_next       = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);
        etype_next     = etype_reg;
        ip_known_next  = ip_known_reg;
        vlan_next      = vlan_reg;
        tcp_start_next = tcp_start_reg;
        is_tcp_next    = is_tcp_reg;
        opt_len_next   = opt_len_reg;
        csum_next      = csum_reg;
        eff_mtu_next   = eff_mtu_reg;
        enable_next    = enable_reg;

        if (pos_reg == '0) begin
            enable_next  = in_item.clamp_enable;
            eff_mtu_next = in_item.source_mtu;
            if (!in_item.via_is_local && (in_item.via_mtu < in_item.source_mtu)) begin
                eff_mtu_next = in_item.via_mtu;
            end
        end

        if (pos_reg == POS_W'(12)) begin
            etype_next = {b, 8'h00};
        end else if (pos_reg == POS_W'(13)) begin
            etype_next    = {etype_reg[15:8], b};
            ip_known_next = 1'b1;
            vlan_next     = ({etype_reg[15:8], b} == ETYPE_VLAN);
        end else if (ip_known_reg && vlan_reg && pos_reg == POS_W'(16)) begin
            etype_next = {b, 8'h00};
        end else if (ip_known_reg && vlan_reg && pos_reg == POS_W'(17)) begin
            etype_next = {etype_reg[15:8], b};
        end

        if (ip_known_reg) begin
            if (pos_reg == ip_begin) begin
                if (etype_reg == ETYPE_IPV4) begin
                    tcp_start_next = ip_begin7 + {1'b0, b[3:0], 2'b00};
                end else if (etype_reg == ETYPE_IPV6) begin
                    tcp_start_next = ip_begin7 + 7'd40;
                end
            end
            if (etype_reg == ETYPE_IPV4 && pos_reg == ip_begin + POS_W'(9)) begin
                is_tcp_next = (b == IP_PROTO_TCP) && (tcp_start_reg >= ip_begin7 + 7'd20);
            end
            if (etype_reg == ETYPE_IPV6 && pos_reg == ip_begin + POS_W'(6)) begin
                is_tcp_next = (b == IP_PROTO_TCP);
            end
        end

        if (is_tcp_reg && tcp_start_reg != 7'd0) begin
            if (pos_reg == ts + POS_W'(12)) begin
                opt_len_next = (doff >= 4'd5) ? {doff - 4'd5, 2'b00} : 6'd0;
            end else if (pos_reg == ts + POS_W'(16)) begin
                csum_next = {b, 8'h00};
            end else if (pos_reg == ts + POS_W'(17)) begin
                csum_next = {csum_reg[15:8], b};
            end
        end
    end

    // option walk next state
    always_comb begin
        scan_next = scan_reg;
        if (scan_en) begin
            case (scan_reg)
                SCAN_KIND: begin
                    if (opt_idx_reg >= opt_len_reg || b == OPT_END) begin
                        scan_next = SCAN_DONE;
                    end else if (b == OPT_NOP) begin
                        scan_next = SCAN_KIND;
                    end else if (idx9 + 9'd2 > len9) begin
                        scan_next = SCAN_DONE;
                    end else begin
                        scan_next = (b == OPT_MSS) ? SCAN_LEN_MSS : SCAN_LEN_OTHER;
                    end
                end
                SCAN_LEN_OTHER: begin
                    if (opt_sum > len9 || b < 8'd2) begin
                        scan_next = SCAN_DONE;
                    end else begin
                        scan_next = (b != 8'd2) ? SCAN_SKIP : SCAN_KIND;
                    end
                end
                SCAN_SKIP: begin
                    if (skip_reg == 8'd1) begin
                        scan_next = SCAN_KIND;
                    end
                end
                SCAN_LEN_MSS: begin
                    scan_next = (opt_sum > len9 || b != OPT_MSS_LEN) ? SCAN_DONE : SCAN_MSS_HI;
                end
                SCAN_MSS_HI: scan_next = SCAN_MSS_LO;
                SCAN_MSS_LO: scan_next = SCAN_DONE;
                default:     scan_next = SCAN_DONE;
            endcase
        end
    end

    // option walk data
    always_comb begin
        opt_idx_next   = opt_idx_reg;
        skip_next      = skip_reg;
        mss_found_next = mss_found_reg;
        mss_pos_next   = mss_pos_reg;
        mss_value_next = mss_value_reg;
        if (scan_en) begin
            case (scan_reg)
                SCAN_KIND: begin
                    if (opt_idx_reg < opt_len_reg && b == OPT_NOP) begin
                        opt_idx_next = opt_idx_reg + 6'd1;
                    end
                end
                SCAN_LEN_OTHER: begin
                    if (!(opt_sum > len9 || b < 8'd2)) begin
                        opt_idx_next = opt_sum[5:0];
                        skip_next    = b - 8'd2;
                    end
                end
                SCAN_SKIP: skip_next = skip_reg - 8'd1;
                SCAN_MSS_HI: begin
                    mss_value_next = {b, 8'h00};
                    mss_pos_next   = pos_reg[10:0];
                end
                SCAN_MSS_LO: begin
                    mss_value_next = {mss_value_reg[15:8], b};
                    mss_found_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign count       = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign ts_next_ext = {{(POS_W-6){1'b0}}, tcp_start_next};

    always_comb begin
        summary.eligible  = enable_next && is_tcp_next && mss_found_next
                            && (count <= (POS_W+1)'(MAX_FRAME))
                            && (count > ts_next_ext + (POS_W+1)'(20))
                            && (count >= ts_next_ext + (POS_W+1)'(20)
                                + {{(POS_W-5){1'b0}}, opt_len_next});
        summary.mss_value = mss_value_next;
        summary.mss_pos   = mss_pos_next;
        summary.tcp_start = tcp_start_next;
        summary.checksum  = csum_next;
        summary.eff_mtu   = eff_mtu_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && in_item.last_byte)) begin
            pos_reg       <= '0;
            etype_reg     <= '0;
            ip_known_reg  <= 1'b0;
            vlan_reg      <= 1'b0;
            tcp_start_reg <= '0;
            is_tcp_reg    <= 1'b0;
            opt_len_reg   <= '0;
            opt_idx_reg   <= '0;
            scan_reg      <= SCAN_KIND;
            skip_reg      <= '0;
            mss_found_reg <= 1'b0;
            mss_pos_reg   <= '0;
            mss_value_reg <= '0;
            csum_reg      <= '0;
            eff_mtu_reg   <= '0;
            enable_reg    <= 1'b0;
        end else if (step) begin
            pos_reg       <= pos_next;
            etype_reg     <= etype_next;
            ip_known_reg  <= ip_known_next;
            vlan_reg      <= vlan_next;
            tcp_start_reg <= tcp_start_next;
            is_tcp_reg    <= is_tcp_next;
            opt_len_reg   <= opt_len_next;
            opt_idx_reg   <= opt_idx_next;
            scan_reg      <= scan_next;
            skip_reg      <= skip_next;
            mss_found_reg <= mss_found_next;
            mss_pos_reg   <= mss_pos_next;
            mss_value_reg <= mss_value_next;
            csum_reg      <= csum_next;
            eff_mtu_reg   <= eff_mtu_next;
            enable_reg    <= enable_next;
        end
    end

endmodule
`default_nettype wire

[src/tcpmc_patch.sv]
`default_nettype none
module tcpmc_patch (
    input  wire tcpmc_pkg::frame_sum_t summary,
    output tcpmc_pkg::out_item_t       result
);
    import tcpmc_pkg::*;

    logic [15:0] new_mss;
    logic [15:0] csum_mid;
    logic        apply;

    assign new_mss  = summary.eff_mtu - {9'b0, summary.tcp_start} - 16'd20;
    assign csum_mid = ~summary.checksum - summary.mss_value + new_mss;
    assign apply    = summary.eligible && (summary.mss_value > new_mss);

    always_comb begin
        result = '0;
        if (apply) begin
            result.clamp_applied   = 1'b1;
            result.mss_offset      = summary.mss_pos;
            result.new_mss         = new_mss;
            result.checksum_offset = {4'b0000, summary.tcp_start} + 11'd16;
            result.new_checksum    = ~csum_mid;
            result.old_mss         = summary.mss_value;
        end
    end

endmodule
`default_nettype wire

[src/tcp_mss_clamp_top.sv]
`default_nettype none
// TCP MSS clamp. Takes an Ethernet frame one byte per item and, on the last
// byte of each frame, gives one result telling whether the MSS option must be
// lowered, with the new MSS, the new TCP checksum and the byte offsets of
// both fields. The block takes one byte per clock cycle while no last byte
// waits; a byte goes through an input register and the per-byte parser into
// the result register. Only a last byte waits, and only while the previous
// result is still held unaccepted.
module tcp_mss_clamp_top (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire tcpmc_pkg::in_item_t  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output tcpmc_pkg::out_item_t      m_data
);
    import tcpmc_pkg::*;

    in_item_t   in_reg;
    logic       in_valid_reg;
    out_item_t  out_reg;
    logic       out_valid_reg;
    logic       out_free;
    logic       step;
    frame_sum_t summary;
    out_item_t  result;

    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && (!in_reg.last_byte || out_free);
    assign s_ready  = !in_valid_reg || step;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    tcpmc_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_item (in_reg),
        .summary (summary)
    );

    tcpmc_patch u_patch (
        .summary (summary),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && in_reg.last_byte) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && in_reg.last_byte) begin
            out_reg <= result;
        end
    end

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(step && in_reg.last_byte))
        else $error("result without a last byte");

    a_no_patch_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.clamp_applied) |->
            (m_data.new_mss == 16'd0 && m_data.old_mss == 16'd0
             && m_data.new_checksum == 16'd0 && m_data.mss_offset == 11'd0
             && m_data.checksum_offset == 11'd0))
        else $error("unpatched result carries data");

    a_patch_lowers: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.clamp_applied) |-> (m_data.new_mss < m_data.old_mss))
        else $error("patch does not lower mss");

    a_last_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && in_valid_reg && in_reg.last_byte) |=>
            (out_valid_reg && $stable(out_reg)))
        else $error("held result overwritten");

endmodule
`default_nettype wire

[tb/sv/tb_clamp_pkg.sv]
package tb_clamp_pkg;
    import tcpmc_pkg::*;

    class clamp_scoreboard;
        int unsigned errors;
        out_item_t expected_patches[$];

        // per-frame parser state
        int unsigned pos;
        logic [15:0] etype;
        int unsigned ip_at;
        int unsigned tcp_at;
        bit          tcp;
        int unsigned opt_len;
        int unsigned opt_idx;
        scan_state_t scan;
        int unsigned skip_left;
        bit          mss_seen;
        int unsigned mss_at;
        logic [15:0] mss_old;
        logic [15:0] csum;
        logic [15:0] eff_mtu;
        bit          enabled;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            pos = 0;
            etype = '0;
            ip_at = 0;
            tcp_at = 0;
            tcp = 1'b0;
            opt_len = 0;
            opt_idx = 0;
            scan = SCAN_KIND;
            skip_left = 0;
            mss_seen = 1'b0;
            mss_at = 0;
            mss_old = '0;
            csum = '0;
            eff_mtu = '0;
            enabled = 1'b0;
        endfunction

        function int pending();
            return expected_patches.size();
        endfunction

        function void walk_option(logic [7:0] b, int unsigned p);
            case (scan)
                SCAN_KIND: begin
                    if (opt_idx >= opt_len || b == OPT_END) scan = SCAN_DONE;
                    else if (b == OPT_NOP) opt_idx++;
                    else if (opt_idx + 2 > opt_len) scan = SCAN_DONE;
                    else scan = (b == OPT_MSS) ? SCAN_LEN_MSS : SCAN_LEN_OTHER;
                end
                SCAN_LEN_OTHER: begin
                    if (opt_idx + b > opt_len || b < 2) begin
                        scan = SCAN_DONE;
                    end else begin
                        opt_idx += b;
                        skip_left = b - 2;
                        scan = (skip_left != 0) ? SCAN_SKIP : SCAN_KIND;
                    end
                end
                SCAN_SKIP: begin
                    skip_left--;
                    if (skip_left == 0) scan = SCAN_KIND;
                end
                SCAN_LEN_MSS: begin
                    if (opt_idx + b > opt_len || b != OPT_MSS_LEN) scan = SCAN_DONE;
                    else scan = SCAN_MSS_HI;
                end
                SCAN_MSS_HI: begin
                    mss_old = {b, 8'h00};
                    mss_at = p;
                    scan = SCAN_MSS_LO;
                end
                SCAN_MSS_LO: begin
                    mss_old[7:0] = b;
                    mss_seen = 1'b1;
                    scan = SCAN_DONE;
                end
                default: scan = SCAN_DONE;
            endcase
        endfunction

        function void parse(logic [7:0] b, int unsigned p);
            int unsigned doff;
            if (p == 12) begin
                etype = {b, 8'h00};
            end else if (p == 13) begin
                etype[7:0] = b;
                ip_at = (etype == ETYPE_VLAN) ? 18 : 14;
            end else if (ip_at == 18 && p == 16) begin
                etype = {b, 8'h00};
            end else if (ip_at == 18 && p == 17) begin
                etype[7:0] = b;
            end

            if (ip_at != 0) begin
                if (p == ip_at) begin
                    if (etype == ETYPE_IPV4) tcp_at = ip_at + int'(b[3:0]) * 4;
                    else if (etype == ETYPE_IPV6) tcp_at = ip_at + 40;
                end
                if (etype == ETYPE_IPV4 && p == ip_at + 9)
                    tcp = (b == IP_PROTO_TCP) && (tcp_at >= ip_at + 20);
                if (etype == ETYPE_IPV6 && p == ip_at + 6)
                    tcp = (b == IP_PROTO_TCP);
            end

            if (tcp && tcp_at != 0) begin
                if (p == tcp_at + 12) begin
                    doff = b[7:4];
                    opt_len = (doff >= 5) ? (doff - 5) * 4 : 0;
                end else if (p == tcp_at + 16) begin
                    csum = {b, 8'h00};
                end else if (p == tcp_at + 17) begin
                    csum[7:0] = b;
                end else if (p >= tcp_at + 20 && scan != SCAN_DONE) begin
                    walk_option(b, p);
                end
            end
        endfunction

        function void take_byte(in_item_t it);
            out_item_t patch;
            logic [15:0] mss_new;
            logic [15:0] sum;
            if (pos == 0) begin
                enabled = it.clamp_enable;
                eff_mtu = it.source_mtu;
                if (!it.via_is_local && it.via_mtu < it.source_mtu) eff_mtu = it.via_mtu;
            end
            parse(it.data_byte, pos);
            pos++;
            if (!it.last_byte) return;

            patch = '0;
            if (enabled && tcp && mss_seen && pos <= MAX_FRAME && pos > tcp_at + 20
                    && pos >= tcp_at + 20 + opt_len) begin
                mss_new = eff_mtu - 16'(tcp_at) - 16'd20;
                if (mss_old > mss_new) begin
                    sum = ~csum;
                    sum = sum - mss_old + mss_new;
                    sum = ~sum;
                    patch.clamp_applied = 1'b1;
                    patch.mss_offset = 11'(mss_at);
                    patch.new_mss = mss_new;
                    patch.checksum_offset = 11'(tcp_at + 16);
                    patch.new_checksum = sum;
                    patch.old_mss = mss_old;
                end
            end
            expected_patches.push_back(patch);
            clear();
        endfunction

        function void field_diff(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch in %s: expected %h, got %h", name, want, got);
            end
        endfunction

        function void check_patch(out_item_t got);
            out_item_t want;
            if (expected_patches.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: %p", got);
                return;
            end
            want = expected_patches.pop_front();
            field_diff("clamp_applied", 16'(want.clamp_applied), 16'(got.clamp_applied));
            field_diff("mss_offset", 16'(want.mss_offset), 16'(got.mss_offset));
            field_diff("new_mss", want.new_mss, got.new_mss);
            field_diff("checksum_offset", 16'(want.checksum_offset),
                       16'(got.checksum_offset));
            field_diff("new_checksum", want.new_checksum, got.new_checksum);
            field_diff("old_mss", want.old_mss, got.old_mss);
        endfunction
    endclass

endpackage

[tb/sv/tb_tcp_mss_clamp_top.sv]
module tb_tcp_mss_clamp_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcpmc_pkg::*;
    import tb_clamp_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [7:0] OPT_WSCALE = 8'd3;
    localparam logic [7:0] OPT_TSTAMP = 8'd8;
    localparam logic [7:0] IP_PROTO_UDP = 8'd17;
    localparam logic [15:0] ETYPE_ARP = 16'h0806;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;

    clamp_scoreboard sb;
    logic [7:0] frame_q[$];
    logic [7:0] opt_bytes[$];
    int burst_left = 0;
    bit no_idle = 1'b0;
    int unsigned bytes_sent = 0;
    int unsigned frames_sent = 0;
    int unsigned cycle_count = 0;
    int unsigned rx_cyc = 0;

    tcp_mss_clamp_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: check, then pick the next ready value
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_patch(m_data);
        rx_cyc++;
        case (2'(rx_cyc >> 8))
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= 1'($urandom);
            2'd2: m_ready <= ((rx_cyc % 7) < 2);
            default: m_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    function automatic void push_rand(int n);
        repeat (n) frame_q.push_back(8'($urandom));
    endfunction

    function automatic void add_opt(logic [7:0] kind, int len);
        opt_bytes.push_back(kind);
        opt_bytes.push_back(8'(len));
        if (len > 2) repeat (len - 2) opt_bytes.push_back(8'($urandom));
    endfunction

    function automatic void add_mss(logic [15:0] v);
        opt_bytes.push_back(OPT_MSS);
        opt_bytes.push_back(OPT_MSS_LEN);
        opt_bytes.push_back(v[15:8]);
        opt_bytes.push_back(v[7:0]);
    endfunction

    function automatic void build_tcp(bit vlan, bit v6, int ihl, logic [7:0] proto, int doff,
                                      logic [15:0] csum, int payload);
        int olen;
        olen = (doff > 5) ? (doff - 5) * 4 : 0;
        frame_q.delete();
        push_rand(12);
        if (vlan) begin
            frame_q.push_back(ETYPE_VLAN[15:8]);
            frame_q.push_back(ETYPE_VLAN[7:0]);
            push_rand(2);
        end
        if (v6) begin
            frame_q.push_back(ETYPE_IPV6[15:8]);
            frame_q.push_back(ETYPE_IPV6[7:0]);
            frame_q.push_back({4'h6, 4'($urandom)});
            push_rand(5);
            frame_q.push_back(proto);
            push_rand(33);
        end else begin
            frame_q.push_back(ETYPE_IPV4[15:8]);
            frame_q.push_back(ETYPE_IPV4[7:0]);
            frame_q.push_back({4'h4, 4'(ihl)});
            push_rand(8);
            frame_q.push_back(proto);
            push_rand((ihl >= 5) ? ihl * 4 - 10 : 10);
        end
        push_rand(12);
        frame_q.push_back({4'(doff), 4'($urandom)});
        push_rand(3);
        frame_q.push_back(csum[15:8]);
        frame_q.push_back(csum[7:0]);
        push_rand(2);
        for (int i = 0; i < olen; i++)
            frame_q.push_back((i < opt_bytes.size()) ? opt_bytes[i] : 8'($urandom));
        push_rand(payload);
    endfunction

    task automatic send_byte(in_item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!no_idle) begin
                gap = $urandom_range(1, 6);
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_data <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.take_byte(it);
        bytes_sent++;
    endtask

    task automatic send_frame(bit en, logic [15:0] smtu, logic [15:0] vmtu, bit via_local,
                              int cut);
        in_item_t it;
        int n;
        n = frame_q.size();
        if (cut > 0 && cut < n) n = cut;
        no_idle = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++) begin
            it.data_byte = frame_q[i];
            it.last_byte = (i == n - 1);
            if (i == 0) begin
                it.clamp_enable = en;
                it.source_mtu = smtu;
                it.via_mtu = vmtu;
                it.via_is_local = via_local;
            end else begin
                it.clamp_enable = 1'($urandom);
                it.source_mtu = 16'($urandom);
                it.via_mtu = 16'($urandom);
                it.via_is_local = 1'($urandom);
            end
            send_byte(it);
        end
        frames_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic run_directed();
        // ipv4 clamp on and off
        opt_bytes.delete(); add_mss(16'd1460);
        build_tcp(0, 0, 5, IP_PROTO_TCP, 6, 16'h1234, 8);
        send_frame(1, 16'd1500, 16'd9000, 0, 0);
        send_frame(0, 16'd1500, 16'd9000, 0, 0);
        // vlan, ihl 7, nops and another option ahead of mss
        opt_bytes.delete();
        opt_bytes.push_back(OPT_NOP); opt_bytes.push_back(OPT_NOP);
        add_opt(OPT_TSTAMP, 10); add_mss(16'hFFFF);
        build_tcp(1, 0, 7, IP_PROTO_TCP, 10, 16'hFFFF, 5);
        send_frame(1, 16'd1500, 16'd1400, 0, 0);
        // ipv6, local via ignored
        opt_bytes.delete(); add_mss(16'd1440);
        build_tcp(0, 1, 5, IP_PROTO_TCP, 6, 16'h0000, 3);
        send_frame(1, 16'd1500, 16'd1280, 1, 0);
        // vlan ipv6, full options field
        opt_bytes.delete();
        add_opt(OPT_WSCALE, 3); opt_bytes.push_back(OPT_NOP); add_mss(16'd9000);
        build_tcp(1, 1, 5, IP_PROTO_TCP, 15, 16'hA5A5, 2);
        send_frame(1, 16'd1500, 16'd1500, 0, 0);
        // short ihl, longest ihl
        opt_bytes.delete(); add_mss(16'd8000);
        build_tcp(0, 0, 4, IP_PROTO_TCP, 6, 16'h5555, 4);
        send_frame(1, 16'd1500, 16'd1500, 0, 0);
        build_tcp(0, 0, 15, IP_PROTO_TCP, 6, 16'h5555, 4);
        send_frame(1, 16'd1500, 16'd1500, 0, 0);
        // not tcp, and not ip at all
        build_tcp(0, 0, 5, IP_PROTO_UDP, 6, 16'h1111, 4);
        send_frame(1, 16'd1500, 16'd1500, 0, 0);
        build_tcp(0, 1, 5, IP_PROTO_UDP, 6, 16'h1111, 4);
        send_frame(1, 16'd1500, 16'd1500, 0, 0);
        build_tcp(0, 0, 5, IP_PROTO_TCP, 6, 16'h1111, 4);
        frame_q[12] = ETYPE_ARP[15:8];
        frame_q[13] = ETYPE_ARP[7:0];
        send_frame(1, 16'd1500, 16'd1500, 0, 0);
        // data offset below five
        build_tcp(0, 0, 5, IP_PROTO_TCP, 3, 16'h2222, 8);
        send_frame(1, 16'd1500, 16'd1500, 0, 0);
        // end of list before mss, a too short length, bad mss length, past the end
        opt_bytes.delete(); opt_bytes.push_back(OPT_END); add_mss(16'd8000);
        build_tcp(0, 0, 5, IP_PROTO_TCP, 7, 16'h3333, 2);
        send_frame(1, 16'd1500, 16'd1500, 0, 0);
        opt_bytes.delete(); add_opt(OPT_TSTAMP, 1); add_mss(16'd8000);
        build_tcp(0, 0, 5, IP_PROTO_TCP, 7, 16'h3333, 2);
        send_frame(1, 16'd1500, 16'd1500, 0, 0);
        opt_bytes.delete(); add_opt(OPT_MSS, 5); add_mss(16'd8000);
        build_tcp(0, 0, 5, IP_PROTO_TCP, 8, 16'h3333, 2);
        send_frame(1, 16'd1500, 16'd1500, 0, 0);
        opt_bytes.delete();
        opt_bytes.push_back(OPT_NOP); opt_bytes.push_back(OPT_NOP); add_mss(16'd8000);
        build_tcp(0, 0, 5, IP_PROTO_TCP, 6, 16'h3333, 2);
        send_frame(1, 16'd1500, 16'd1500, 0, 0);
        // mss equal to and one above the new value
        opt_bytes.delete(); add_mss(16'd1446);
        build_tcp(0, 0, 5, IP_PROTO_TCP, 6, 16'h4444, 1);
        send_frame(1, 16'd1500, 16'd1500, 0, 0);
        opt_bytes.delete(); add_mss(16'd1447);
        build_tcp(0, 0, 5, IP_PROTO_TCP, 6, 16'h4444, 1);
        send_frame(1, 16'd1500, 16'd1500, 0, 0);
        // wrap of the new mss
        opt_bytes.delete(); add_mss(16'hFFFF);
        build_tcp(0, 0, 5, IP_PROTO_TCP, 6, 16'hFFFF, 1);
        send_frame(1, 16'd0, 16'hFFFF, 1, 0);
        send_frame(1, 16'hFFFF, 16'hFFFF, 0, 0);
        // short and truncated frames
        build_tcp(0, 0, 5, IP_PROTO_TCP, 5, 16'h6666, 0);
        send_frame(1, 16'd1500, 16'd1500, 0, 0);
        opt_bytes.delete(); add_mss(16'd1460);
        build_tcp(0, 0, 5, IP_PROTO_TCP, 6, 16'h6666, 0);
        send_frame(1, 16'd1500, 16'd1500, 0, 58);
        send_frame(1, 16'd1500, 16'd1500, 0, 57);
        build_tcp(0, 0, 5, IP_PROTO_TCP, 7, 16'h6666, 0);
        send_frame(1, 16'd1500, 16'd1500, 0, 58);
        // one byte frame
        frame_q.delete(); push_rand(1);
        send_frame(1, 16'd1500, 16'd1500, 0, 0);
        // longest frame and one byte past it
        opt_bytes.delete(); add_mss(16'd1460);
        build_tcp(0, 0, 5, IP_PROTO_TCP, 6, 16'h7777, 1990);
        send_frame(1, 16'd1500, 16'd1500, 0, 0);
        build_tcp(0, 0, 5, IP_PROTO_TCP, 6, 16'h7777, 1991);
        send_frame(1, 16'd1500, 16'd1500, 0, 0);
    endtask

    function automatic logic [15:0] pick_mtu();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'hFFFF;
            2: return 16'd0;
            default: return 16'($urandom_range(576, 9000));
        endcase
    endfunction

    task automatic random_frame();
        bit en;
        logic [15:0] smtu;
        logic [15:0] vmtu;
        logic [15:0] mss;
        int doff;
        int olen;
        int len;
        int cut;
        en = ($urandom_range(0, 7) != 0);
        smtu = pick_mtu();
        vmtu = pick_mtu();
        cut = 0;
        if ($urandom_range(0, 9) < 8) begin
            doff = $urandom_range(6, 15);
            olen = (doff - 5) * 4;
            opt_bytes.delete();
            repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(0, 1) == 0) begin
                    if (opt_bytes.size() + 5 <= olen) opt_bytes.push_back(OPT_NOP);
                end else begin
                    len = $urandom_range(2, 8);
                    if (opt_bytes.size() + len + 4 <= olen)
                        add_opt(($urandom_range(0, 1) != 0) ? OPT_TSTAMP : OPT_WSCALE, len);
                end
            end
            mss = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 1500)) : 16'($urandom);
            if (opt_bytes.size() + 4 <= olen) add_mss(mss);
            build_tcp(1'($urandom), 1'($urandom), $urandom_range(5, 15),
                      ($urandom_range(0, 15) != 0) ? IP_PROTO_TCP : 8'($urandom),
                      doff, 16'($urandom), $urandom_range(0, 30));
            if ($urandom_range(0, 9) == 0)
                frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom);
            if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, frame_q.size());
        end else begin
            frame_q.delete();
            push_rand($urandom_range(1, 100));
            if (frame_q.size() > 13 && $urandom_range(0, 1) != 0) begin
                frame_q[12] = ($urandom_range(0, 1) != 0) ? ETYPE_IPV4[15:8] : ETYPE_IPV6[15:8];
                frame_q[13] = (frame_q[12] == ETYPE_IPV4[15:8]) ? ETYPE_IPV4[7:0]
                                                               : ETYPE_IPV6[7:0];
            end
        end
        send_frame(en, smtu, vmtu, 1'($urandom), cut);
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        drain();
        while (bytes_sent < 750 + 4200 || frames_sent < 80) begin
            random_frame();
            if (frames_sent % 16 == 0) drain();
        end
        drain();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
